### rtl/rtct_pkg.sv
// shared types and constants of the region thread count tuner
package rtct_pkg;

  // fixed widths of the request and result fields
  localparam int KEY_BITS        = 64;
  localparam int MEAS_BITS       = 32;
  localparam int TC_BITS         = 12;
  localparam int IDX_BITS        = 6;
  localparam int CFG_INDEX_BITS  = 2;

  // register reset values
  localparam int RESET_CORES     = 64;
  localparam int RESET_START     = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_NUM_CORES     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_THREADS = 2'd1;

  // request modes
  localparam logic MODE_BEGIN = 1'b0;
  localparam logic MODE_END   = 1'b1;

  // per-region search phase
  typedef enum logic [2:0] {
    PH_REPEAT = 3'd0,
    PH_FIRST  = 3'd1,
    PH_GROW   = 3'd2,
    PH_REFINE = 3'd3,
    PH_LAST   = 3'd4,
    PH_END    = 3'd5
  } phase_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan;
    logic take_hit;
    logic alloc;
    logic full;
    logic no_region;
    logic rec_read;
    logic step;
    logic emit;
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic mode;
    logic hit;
    logic miss;
    logic count_full;
    logic cur_valid;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/rtct_ram.sv
// generic single-port-write ram with registered read
module rtct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rtct_ctrl.sv
// controller state machine of the region thread count tuner
module rtct_ctrl
  import rtct_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output ctrl_cmd_t  cmd,
  input  dp_status_t status
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_SCAN     = 6'b000100,
    S_LOAD     = 6'b001000,
    S_STEP     = 6'b010000,
    S_EMIT     = 6'b100000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.mode == MODE_BEGIN) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (status.cur_valid) begin
          state_next = S_LOAD;
        end else begin
          cmd.no_region = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (status.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = S_LOAD;
        end else if (status.miss) begin
          if (status.count_full) begin
            cmd.full = 1'b1;
          end else begin
            cmd.alloc = 1'b1;
          end
          state_next = S_EMIT;
        end
      end
      S_LOAD: begin
        cmd.rec_read = 1'b1;
        state_next   = S_STEP;
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/rtct_dp.sv
// datapath of the region thread count tuner: tables, key scan, search step
module rtct_dp
  import rtct_pkg::*;
#(
  parameter int MAX_REGIONS = 64,
  parameter int THREAD_BITS = 11,
  parameter int ENERGY_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [THREAD_BITS-1:0]    cfg_data,
  input  logic                      mode,
  input  logic [KEY_BITS-1:0]       region_key,
  input  logic [MEAS_BITS-1:0]      measured_energy,
  input  ctrl_cmd_t                 cmd,
  output dp_status_t                status,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [TC_BITS-1:0]        thread_count,
  output logic [IDX_BITS-1:0]       region_index,
  output logic                      search_finished,
  output logic                      table_full
);

  localparam int TW = THREAD_BITS + 1;
  localparam int SW = $clog2(MAX_REGIONS);
  localparam int CW = $clog2(MAX_REGIONS + 1);

  typedef struct packed {
    phase_t                 phase;
    logic [TW-1:0]          trial;
    logic [ENERGY_BITS-1:0] best_e;
    logic [TW-1:0]          best_t;
    logic [TW-1:0]          prev;
    logic [TW-1:0]          step;
    logic                   base;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  function automatic logic [TW-1:0] sat_sub(input logic [TW-1:0] a, input logic [TW-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  // configuration
  logic [THREAD_BITS-1:0] num_cores, start_threads;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cores     <= THREAD_BITS'(RESET_CORES);
      start_threads <= THREAD_BITS'(RESET_START);
    end else if (cfg_write) begin
      if (cfg_index == CFG_NUM_CORES) begin
        num_cores <= cfg_data;
      end else if (cfg_index == CFG_START_THREADS) begin
        start_threads <= cfg_data;
      end
    end
  end

  // captured request
  logic                   mode_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [ENERGY_BITS-1:0] energy_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q   <= mode;
      key_q    <= region_key;
      energy_q <= ENERGY_BITS'(measured_energy);
    end
  end

  // region bookkeeping
  logic [CW-1:0] count;
  logic [SW-1:0] cur;
  logic          cur_valid;
  logic [CW-1:0] scan_idx;
  logic          cmp_valid;
  logic [SW-1:0] cmp_idx;
  logic          more, hit, count_full;

  logic [KEY_BITS-1:0] key_rdata;
  rec_t                rec_rdata, rec_wdata, nrec, init_rec;
  logic                rec_we;
  logic [SW-1:0]       rec_waddr;

  assign more       = (scan_idx < count);
  assign hit        = cmp_valid && (key_rdata == key_q);
  assign count_full = (count == CW'(MAX_REGIONS));

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      cur       <= '0;
      cur_valid <= 1'b0;
      cmp_valid <= 1'b0;
      scan_idx  <= '0;
    end else begin
      if (cmd.scan_start) begin
        scan_idx  <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid <= more && !hit;
        if (more) begin
          scan_idx <= scan_idx + CW'(1);
        end
      end
      if (cmd.take_hit) begin
        cur       <= cmp_idx;
        cur_valid <= 1'b1;
      end else if (cmd.alloc) begin
        cur       <= count[SW-1:0];
        cur_valid <= 1'b1;
        count     <= count + CW'(1);
      end else if (cmd.full) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx <= scan_idx[SW-1:0];
    end
  end

  rtct_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_REGIONS)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.alloc),
    .waddr (count[SW-1:0]),
    .wdata (key_q),
    .raddr (scan_idx[SW-1:0]),
    .rdata (key_rdata)
  );

  // search record per region
  always_comb begin
    init_rec        = '0;
    init_rec.phase  = PH_REPEAT;
    init_rec.trial  = TW'(num_cores);
  end

  assign rec_we    = cmd.alloc || (cmd.step && (mode_q == MODE_END));
  assign rec_waddr = cmd.alloc ? count[SW-1:0] : cur;
  assign rec_wdata = cmd.alloc ? init_rec : nrec;

  rtct_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_REGIONS)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (cur),
    .rdata (rec_rdata)
  );

  // one search step on the loaded record
  logic [TW-1:0] start2, half_nc, rstep, rdown, rup, hstep;
  logic [TW:0]   trial2, nc_ext;
  logic          e_lt, best_lt;

  always_comb begin
    start2  = {start_threads, 1'b0};
    half_nc = TW'(num_cores >> 1);
    trial2  = {rec_rdata.trial, 1'b0};
    nc_ext  = (TW + 1)'(num_cores);
    rstep   = rec_rdata.prev >> 1;
    rdown   = sat_sub(rec_rdata.trial, rstep);
    rup     = sat_add(rec_rdata.trial, rstep);
    hstep   = rec_rdata.step >> 1;
    e_lt    = energy_q < rec_rdata.best_e;
    best_lt = rec_rdata.best_e < energy_q;

    nrec = rec_rdata;
    case (rec_rdata.phase)
      PH_REPEAT: begin
        nrec.phase = PH_FIRST;
        nrec.trial = TW'(start_threads);
        nrec.prev  = TW'(start_threads);
      end
      PH_FIRST: begin
        nrec.best_e = energy_q;
        nrec.best_t = rec_rdata.trial;
        nrec.trial  = sat_add(rec_rdata.trial, rec_rdata.trial);
        nrec.phase  = PH_GROW;
      end
      PH_GROW: begin
        if (e_lt) begin
          nrec.best_e = energy_q;
          nrec.best_t = rec_rdata.trial;
          if (rec_rdata.base) begin
            nrec.phase = PH_END;
          end else if (trial2 <= nc_ext) begin
            nrec.prev  = rec_rdata.trial;
            nrec.trial = sat_add(rec_rdata.trial, rec_rdata.trial);
          end else begin
            nrec.step  = rstep;
            nrec.trial = rdown;
            nrec.phase = (rstep == TW'(1)) ? PH_LAST : PH_REFINE;
          end
        end else if ((rec_rdata.trial == start2) && !rec_rdata.base) begin
          nrec.prev  = rec_rdata.trial;
          nrec.trial = TW'(1);
          nrec.base  = 1'b1;
        end else begin
          // step down from the top of the range, otherwise upwards
          nrec.step  = rstep;
          nrec.trial = (rec_rdata.best_t == half_nc) ? rdown : rup;
          nrec.phase = (rstep == TW'(1)) ? PH_LAST : PH_REFINE;
        end
      end
      PH_REFINE: begin
        if (!best_lt) begin
          nrec.best_t = rec_rdata.trial;
          nrec.best_e = energy_q;
        end
        nrec.step  = hstep;
        nrec.trial = sat_add(rec_rdata.trial, hstep);
        nrec.phase = (hstep == TW'(1)) ? PH_LAST : PH_REFINE;
      end
      PH_LAST: begin
        nrec.phase = PH_END;
        if (e_lt) begin
          nrec.best_t = rec_rdata.trial;
        end
      end
      default: begin
        nrec = rec_rdata;
      end
    endcase
  end

  // staged result and output register
  rec_t          shown;
  logic [TW-1:0] st_tc;
  logic [SW-1:0] st_idx;
  logic          st_fin, st_full;

  assign shown = (mode_q == MODE_END) ? nrec : rec_rdata;

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      st_idx  <= cur;
      st_full <= 1'b0;
      if (shown.phase == PH_END) begin
        st_tc  <= shown.best_t;
        st_fin <= 1'b1;
      end else begin
        st_tc  <= shown.trial;
        st_fin <= 1'b0;
      end
    end else if (cmd.alloc) begin
      st_tc   <= TW'(num_cores);
      st_idx  <= count[SW-1:0];
      st_fin  <= 1'b0;
      st_full <= 1'b0;
    end else if (cmd.full || cmd.no_region) begin
      st_tc   <= TW'(num_cores);
      st_idx  <= '0;
      st_fin  <= 1'b0;
      st_full <= cmd.full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      thread_count    <= TC_BITS'(st_tc);
      region_index    <= IDX_BITS'(st_idx);
      search_finished <= st_fin;
      table_full      <= st_full;
    end
  end

  always_comb begin
    status.mode       = mode_q;
    status.hit        = hit;
    status.miss       = !cmp_valid && !more;
    status.count_full = count_full;
    status.cur_valid  = cur_valid;
    status.out_free   = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_REGIONS))
    else $error("region count beyond table size");

  a_alloc_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |-> !count_full)
    else $error("allocation into a full table");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |=> count == $past(count) + CW'(1))
    else $error("allocation did not advance the count");

  a_cur_allocated: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> ({1'b0, cur} < (SW + 1)'(count)))
    else $error("current region points past allocated slots");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result shown without emit");
`endif

endmodule

### rtl/region_thread_count_tuner.sv
// top level of the region thread count tuner
//
//  port group   | kind          | contents
//  -------------+---------------+----------------------------------------------
//  in_*         | valid/ready   | request: mode, region_key, measured_energy
//  out_*        | valid/ready   | result: thread_count, region_index,
//               |               |   search_finished, table_full
//  cfg_*        | write only    | cfg_write, cfg_index, cfg_data
//
//  one request at a time; an end request runs dispatch, record load, step and emit in
//  that order, or dispatch then emit when no region is current; a begin request scans
//  the key memory, one key memory read a cycle, then load and step on a hit or straight
//  to emit on a miss; emit waits for a free output register, then the block goes idle
//  and a new request is taken while a result still waits in the output register
//  synchronous active-high reset clears control state; the key and record
//  memories need no clearing pass, as only allocated slots are ever read
module region_thread_count_tuner
  import rtct_pkg::*;
#(
  parameter int MAX_REGIONS = 64,
  parameter int THREAD_BITS = 11,
  parameter int ENERGY_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic [KEY_BITS-1:0]       region_key,
  input  logic [MEAS_BITS-1:0]      measured_energy,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [TC_BITS-1:0]        thread_count,
  output logic [IDX_BITS-1:0]       region_index,
  output logic                      search_finished,
  output logic                      table_full,
  // configuration write port
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [THREAD_BITS-1:0]    cfg_data
);

  // command and status between the sequencer and the datapath
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: accepts a request, drives the scan, record load, step and emit
  rtct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // datapath: key and record memories, search step, output register
  rtct_dp #(
    .MAX_REGIONS (MAX_REGIONS),
    .THREAD_BITS (THREAD_BITS),
    .ENERGY_BITS (ENERGY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mode            (mode),
    .region_key      (region_key),
    .measured_energy (measured_energy),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .thread_count    (thread_count),
    .region_index    (region_index),
    .search_finished (search_finished),
    .table_full      (table_full)
  );

endmodule

### tb/rtct_checker.sv
// result checker for the region thread count tuner: tracks requests, predicts and compares
module rtct_checker
  import rtct_pkg::*;
#(
  parameter int MAX_REGIONS = 64,
  parameter int THREAD_BITS = 11,
  parameter int ENERGY_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      mode,
  input  logic [KEY_BITS-1:0]       region_key,
  input  logic [MEAS_BITS-1:0]      measured_energy,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [TC_BITS-1:0]        thread_count,
  input  logic [IDX_BITS-1:0]       region_index,
  input  logic                      search_finished,
  input  logic                      table_full,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [THREAD_BITS-1:0]    cfg_data,
  output int unsigned               fail_count,
  output int unsigned               results_owed,
  output int unsigned               finished_seen,
  output int unsigned               full_seen
);

  // thread counts carry one extra bit so a doubled trial fits
  localparam int TW = THREAD_BITS + 1;
  typedef logic [TW-1:0] tcount_t;
  typedef logic [ENERGY_BITS-1:0] energy_t;
  localparam tcount_t TMAX = {TW{1'b1}};

  typedef struct packed {
    logic [TC_BITS-1:0]  tc;
    logic [IDX_BITS-1:0] idx;
    logic                fin;
    logic                full;
  } tuner_result_t;

  tuner_result_t awaited_results[$];

  logic [THREAD_BITS-1:0] cores;
  logic [THREAD_BITS-1:0] first_trial;
  int unsigned            used_slots;
  int unsigned            cur_slot;
  logic                   cur_ok;

  logic [KEY_BITS-1:0] key_mem     [MAX_REGIONS];
  phase_t              phase_mem   [MAX_REGIONS];
  tcount_t             trial_mem   [MAX_REGIONS];
  tcount_t             best_thr_mem[MAX_REGIONS];
  tcount_t             prev_mem    [MAX_REGIONS];
  tcount_t             step_mem    [MAX_REGIONS];
  energy_t             best_en_mem [MAX_REGIONS];
  logic                base_done   [MAX_REGIONS];

  function automatic tcount_t sat_sum(tcount_t a, tcount_t b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, TMAX}) ? TMAX : s[TW-1:0];
  endfunction

  function automatic tcount_t sat_diff(tcount_t a, tcount_t b);
    return (a > b) ? a - b : '0;
  endfunction

  task automatic claim_slot(input int unsigned s, input logic [KEY_BITS-1:0] k);
    key_mem[s]      = k;
    phase_mem[s]    = PH_REPEAT;
    trial_mem[s]    = tcount_t'(cores);
    best_en_mem[s]  = '0;
    best_thr_mem[s] = '0;
    prev_mem[s]     = '0;
    step_mem[s]     = '0;
    base_done[s]    = 1'b0;
  endtask

  // step is half the previous count, then move down or up by it
  task automatic refine_from(input int unsigned s, input logic down);
    step_mem[s]  = prev_mem[s] >> 1;
    trial_mem[s] = down ? sat_diff(trial_mem[s], step_mem[s])
                        : sat_sum(trial_mem[s], step_mem[s]);
    phase_mem[s] = (step_mem[s] == tcount_t'(1)) ? PH_LAST : PH_REFINE;
  endtask

  task automatic advance_search(input int unsigned s, input energy_t e);
    logic [TW:0] doubled;
    logic [TW:0] twice_start;
    doubled     = {trial_mem[s], 1'b0};
    twice_start = {2'b00, first_trial} << 1;
    case (phase_mem[s])
      PH_REPEAT: begin
        phase_mem[s] = PH_FIRST;
        trial_mem[s] = tcount_t'(first_trial);
        prev_mem[s]  = tcount_t'(first_trial);
      end
      PH_FIRST: begin
        best_en_mem[s]  = e;
        best_thr_mem[s] = trial_mem[s];
        trial_mem[s]    = sat_sum(trial_mem[s], trial_mem[s]);
        phase_mem[s]    = PH_GROW;
      end
      PH_GROW: begin
        if (e < best_en_mem[s]) begin
          best_en_mem[s]  = e;
          best_thr_mem[s] = trial_mem[s];
          if (base_done[s]) begin
            phase_mem[s] = PH_END;
          end else if (doubled <= cores) begin
            prev_mem[s]  = trial_mem[s];
            trial_mem[s] = sat_sum(trial_mem[s], trial_mem[s]);
          end else begin
            refine_from(s, 1'b1);
          end
        end else if ({1'b0, trial_mem[s]} == twice_start && !base_done[s]) begin
          // one-thread baseline run
          prev_mem[s]  = trial_mem[s];
          trial_mem[s] = tcount_t'(1);
          base_done[s] = 1'b1;
        end else if (best_thr_mem[s] == (cores >> 1)) begin
          refine_from(s, 1'b1);
        end else begin
          refine_from(s, 1'b0);
        end
      end
      PH_REFINE: begin
        if (!(best_en_mem[s] < e)) begin
          best_thr_mem[s] = trial_mem[s];
          best_en_mem[s]  = e;
        end
        step_mem[s]  = step_mem[s] >> 1;
        trial_mem[s] = sat_sum(trial_mem[s], step_mem[s]);
        phase_mem[s] = (step_mem[s] == tcount_t'(1)) ? PH_LAST : PH_REFINE;
      end
      PH_LAST: begin
        phase_mem[s] = PH_END;
        if (e < best_en_mem[s]) best_thr_mem[s] = trial_mem[s];
      end
      default: begin
      end
    endcase
  endtask

  task automatic predict_result(input logic m, input logic [KEY_BITS-1:0] k,
                                input energy_t e, output tuner_result_t r);
    logic        found;
    logic        settled;
    int unsigned i;
    found   = 1'b0;
    settled = 1'b0;
    r.tc    = TC_BITS'(cores);
    r.idx   = '0;
    r.fin   = 1'b0;
    r.full  = 1'b0;
    if (m == MODE_BEGIN) begin
      for (i = 0; i < used_slots && !found; i++) begin
        if (key_mem[i] == k) begin
          cur_slot = i;
          found    = 1'b1;
        end
      end
      if (!found) begin
        if (used_slots < MAX_REGIONS) begin
          cur_slot = used_slots;
          claim_slot(used_slots, k);
          used_slots++;
        end else begin
          cur_ok  = 1'b0;
          r.full  = 1'b1;
          settled = 1'b1;
        end
      end
      if (!settled) cur_ok = 1'b1;
    end else if (!cur_ok) begin
      settled = 1'b1;
    end else begin
      advance_search(cur_slot, e);
    end
    if (!settled) begin
      r.idx = IDX_BITS'(cur_slot);
      if (phase_mem[cur_slot] == PH_END) begin
        r.tc  = TC_BITS'(best_thr_mem[cur_slot]);
        r.fin = 1'b1;
      end else begin
        r.tc = TC_BITS'(trial_mem[cur_slot]);
      end
    end
  endtask

  // four-state compare, so an unknown result bit counts as a mismatch
  function automatic void check_field(string name, logic [63:0] want,
                                      logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    tuner_result_t want;
    tuner_result_t fresh;
    if (rst) begin
      cores       = THREAD_BITS'(RESET_CORES);
      first_trial = THREAD_BITS'(RESET_START);
      used_slots  = 0;
      cur_slot    = 0;
      cur_ok      = 1'b0;
      awaited_results.delete();
      fail_count    = 0;
      finished_seen = 0;
      full_seen     = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_NUM_CORES) cores = cfg_data;
        else if (cfg_index == CFG_START_THREADS) first_trial = cfg_data;
      end
      // compare before queueing, so a stray result never takes a fresh entry
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing awaited: thread_count %0d region_index %0d",
                 thread_count, region_index);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("thread_count", 64'(want.tc), 64'(thread_count));
          check_field("region_index", 64'(want.idx), 64'(region_index));
          check_field("search_finished", 64'(want.fin), 64'(search_finished));
          check_field("table_full", 64'(want.full), 64'(table_full));
        end
        if (search_finished) finished_seen++;
        if (table_full) full_seen++;
      end
      if (in_valid && in_ready) begin
        predict_result(mode, region_key, energy_t'(measured_energy), fresh);
        awaited_results.push_back(fresh);
      end
    end
    results_owed = awaited_results.size();
  end

endmodule

### tb/tb.sv
// testbench top for the region thread count tuner: stimulus, idling and verdict
module tb
  import rtct_pkg::*;
();

  localparam int THREAD_BITS = 11;
  localparam int SLOTS       = 64;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic                      mode;
  logic [KEY_BITS-1:0]       region_key;
  logic [MEAS_BITS-1:0]      measured_energy;
  logic                      out_valid;
  logic                      out_ready;
  logic [TC_BITS-1:0]        thread_count;
  logic [IDX_BITS-1:0]       region_index;
  logic                      search_finished;
  logic                      table_full;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [THREAD_BITS-1:0]    cfg_data;

  int unsigned fail_count;
  int unsigned results_owed;
  int unsigned finished_seen;
  int unsigned full_seen;

  // set for the closing phase: no gaps on either side from then on
  bit calm = 1'b0;

  // every key ever sent in a begin request, allocated or not
  logic [KEY_BITS-1:0] known_keys[$];
  int unsigned begins_sent = 0;
  int unsigned ends_sent   = 0;

  always #1 clk = ~clk;

  region_thread_count_tuner DUT (.*);

  rtct_checker checker_i (.*);

  // result side back-pressure: out_ready drops at random, except in the closing phase
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // hard stop in case the handshakes hang
  initial begin
    #2000000;
    $display("[region_thread_count_tuner] ERROR");
    $finish;
  end

  // one request: optional gap, then hold valid and payload until accepted;
  // entered and left at a falling edge
  task automatic push_request(input logic m, input logic [KEY_BITS-1:0] k,
                              input logic [MEAS_BITS-1:0] e);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    mode            <= m;
    region_key      <= k;
    measured_energy <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // begin requests carry a don't-care energy, end requests a don't-care key
  task automatic send_begin(input logic [KEY_BITS-1:0] k);
    push_request(MODE_BEGIN, k, $urandom);
    begins_sent++;
  endtask

  task automatic send_end(input logic [MEAS_BITS-1:0] e);
    push_request(MODE_END, {$urandom, $urandom}, e);
    ends_sent++;
  endtask

  task automatic open_fresh();
    logic [KEY_BITS-1:0] k;
    k = {$urandom, $urandom};
    known_keys.push_back(k);
    send_begin(k);
  endtask

  // drop valid and hold off until every request has its result back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
  endtask

  // both registers on back-to-back cycles, write strobe held across them
  task automatic write_regs(input int unsigned cores, input int unsigned start);
    cfg_write <= 1'b1;
    cfg_index <= CFG_NUM_CORES;
    cfg_data  <= THREAD_BITS'(cores);
    @(negedge clk);
    cfg_index <= CFG_START_THREADS;
    cfg_data  <= THREAD_BITS'(start);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // mostly well-formed traffic: a begin followed by a run of end requests whose
  // energies follow a shape, so searches get past the doubling phase; the rest
  // is noise (lone ends, bare begins, brand-new keys)
  task automatic random_traffic(input int unsigned n, input int unsigned fresh_pct);
    int unsigned         sent;
    int unsigned         n_end;
    int unsigned         turn;
    int unsigned         shape;
    int unsigned         j;
    logic [MEAS_BITS-1:0] lvl;
    logic [MEAS_BITS-1:0] d;
    logic [MEAS_BITS-1:0] e;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 99) < fresh_pct) open_fresh();
        else send_begin(known_keys[$urandom_range(0, known_keys.size() - 1)]);
        sent++;
        n_end = $urandom_range(1, 9);
        turn  = $urandom_range(1, n_end);
        shape = $urandom_range(0, 3);
        lvl   = $urandom;
        for (j = 0; j < n_end; j++) begin
          d = $urandom_range(0, 5000);
          case (shape)
            0: e = $urandom;
            // shape 1 falls then climbs, shape 2 only climbs
            1, 2: begin
              if (shape == 1 && j < turn) e = (lvl > d) ? lvl - d : '0;
              else e = (lvl < ~d) ? lvl + d : '1;
              lvl = e;
            end
            // tiny values so that equal energies turn up often
            default: e = $urandom_range(0, 3);
          endcase
          if ($urandom_range(0, 19) == 0) e = $urandom_range(0, 1) ? '1 : '0;
          send_end(e);
          sent++;
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       send_end($urandom);
          1:       open_fresh();
          default: send_begin(known_keys[$urandom_range(0, known_keys.size() - 1)]);
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned cores_set[6];
    int unsigned start_set[6];
    int unsigned p;
    cores_set = '{1024, 1, 1024, 12, 0, 64};
    start_set = '{2, 1, 1024, 3, 0, 2};

    rst             = 1'b1;
    in_valid        = 1'b0;
    mode            = MODE_BEGIN;
    region_key      = '0;
    measured_energy = '0;
    cfg_write       = 1'b0;
    cfg_index       = CFG_NUM_CORES;
    cfg_data        = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part under the reset settings (64 cores, first trial 2)
    send_end('0);                      // end with no current region yet
    send_begin('0);                    // all-zero key takes slot 0
    send_end('1);                      // repeat run, result discarded
    send_end('1);                      // first trial at 2, then doubling
    send_end('0);                      // improvement: keep doubling
    send_end('0);                      // no gain: refinement upwards
    send_end('0);                      // tie during refinement keeps new count
    send_end(32'd5);                   // last comparison ends the search
    send_end(32'h8000_0000);           // end while finished: nothing moves
    send_begin('1);                    // all-ones key takes slot 1
    send_end(32'd100);
    send_end(32'd100);
    send_end(32'd200);                 // worse at twice the start: one-thread baseline
    send_end(32'd50);                  // baseline wins, search over
    send_begin('0);                    // lookup hit on a finished region
    send_begin({KEY_BITS/2{2'b10}});
    send_end(32'd7);
    send_begin({KEY_BITS/2{2'b01}});
    send_end(32'd7);
    send_begin('1);                    // lookup hit on a second finished region
    known_keys.push_back('0);
    known_keys.push_back('1);
    known_keys.push_back({KEY_BITS/2{2'b10}});
    known_keys.push_back({KEY_BITS/2{2'b01}});
    wait_idle();

    // random phases, each under its own register setting; the block is idle
    // at every change, and the last phase runs with no gaps at all
    for (p = 0; p < 6; p++) begin
      if (p == 4) write_regs($urandom_range(1, 1024), $urandom_range(1, 1024));
      else write_regs(cores_set[p], start_set[p]);
      if (p == 5) begin
        calm = 1'b1;
        // fill the table past its size so new keys come back as full
        while (known_keys.size() < SLOTS + 3) begin
          open_fresh();
          if ($urandom_range(0, 2) == 0) send_end($urandom);
        end
        send_end($urandom);            // end after a full-table answer
      end
      random_traffic(145, 25);
      wait_idle();
    end

    repeat (80) @(negedge clk);

    $display("covered %0d begin and %0d end requests over %0d keys, 7 register settings",
             begins_sent, ends_sent, known_keys.size());
    $display("%0d results showed a finished search, %0d a full table",
             finished_seen, full_seen);
    if (fail_count == 0 && results_owed == 0) begin
      $display("[region_thread_count_tuner] OK");
    end else begin
      $display("[region_thread_count_tuner] ERROR");
    end
    $finish;
  end

endmodule
